FILE: hw/rtl/hcc_pkg.sv
// Types and constants shared by the hysteresis charge controller.
package hcc_pkg;

  typedef enum logic [1:0] {
    MODE_ALWAYS_ON = 2'd0,
    MODE_DAY       = 2'd1,
    MODE_NIGHT     = 2'd2
  } mode_t;

  localparam logic [1:0] MODE_INVALID = 2'd3;

  localparam logic [2:0] STATUS_NOT_REPORTED = 3'd0;
  localparam logic [2:0] STATUS_CHARGING     = 3'd2;
  localparam logic [2:0] STATUS_DISCHARGING  = 3'd3;
  localparam logic [2:0] STATUS_FULL         = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_CHARGE_MODE        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DAY_LOW_PERCENT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DAY_HIGH_PERCENT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NIGHT_LOW_PERCENT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NIGHT_HIGH_PERCENT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ALERT_AFTER_TICKS  = 3'd5;

  localparam mode_t      RESET_CHARGE_MODE        = MODE_DAY;
  localparam logic [6:0] RESET_DAY_LOW_PERCENT    = 7'd55;
  localparam logic [6:0] RESET_DAY_HIGH_PERCENT   = 7'd65;
  localparam logic [6:0] RESET_NIGHT_LOW_PERCENT  = 7'd90;
  localparam logic [6:0] RESET_NIGHT_HIGH_PERCENT = 7'd95;
  localparam logic [7:0] RESET_ALERT_AFTER_TICKS  = 8'd5;

  typedef struct packed {
    logic [6:0] battery_percent;
    logic       device_connected;
    logic [2:0] os_status;
    logic       port_unplugged;
  } item_t;

  typedef struct packed {
    logic       command_sent;
    logic       charger_on;
    logic       retry_on;
    logic       charging_now;
    logic       discharging_flag;
    logic [7:0] mismatch_ticks;
    logic       alert_raised;
    logic       alert_cleared;
  } result_t;

endpackage

FILE: hw/rtl/hysteresis_charge_controller_core.sv
// Hysteresis charge controller: one tick word in, one result word out.
//
// Each accepted tick word is decided in the cycle it is taken and its result
// word is registered into the result register, or into the skid register
// while a result is stalled, so the block takes one word per clock unless
// item_stall is high. A two-entry output buffer (result register plus
// skid register) lets the block take a new word while a result is stalled,
// and item_stall rises only when both entries are full. The configuration
// port is always ready; register writes take effect on the following cycle.
// COUNT_BITS sets the mismatch counter width; the reported count is capped
// at 255.
module hysteresis_charge_controller_core
  import hcc_pkg::*;
#(
  parameter int COUNT_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  mode_t                  charge_mode;
  logic [6:0]             day_low_percent;
  logic [6:0]             day_high_percent;
  logic [6:0]             night_low_percent;
  logic [6:0]             night_high_percent;
  logic [7:0]             alert_after_ticks;

  logic                   discharging;
  logic                   discharging_next;
  logic [COUNT_BITS-1:0]  mismatch_counter;
  logic [COUNT_BITS-1:0]  mismatch_counter_next;
  logic                   alert_active;
  logic                   alert_active_next;
  logic                   charging_state;
  logic                   charging_state_next;

  result_t                result_next;
  result_t                skid;
  logic                   skid_valid;

  logic                   accept;
  logic                   take;
  logic                   cfg_write;
  logic                   mode_change;
  logic [1:0]             mode_value;
  logic                   use_window;
  logic [6:0]             win_low;
  logic [6:0]             win_high;
  logic                   on;
  logic                   port_off;
  logic [7:0]             shown_count;

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign mode_value = cfg_data[1:0];
  assign mode_change = cfg_write && (cfg_index == REG_CHARGE_MODE)
                       && (mode_value != MODE_INVALID)
                       && (mode_value != charge_mode);

  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign take       = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      charge_mode        <= RESET_CHARGE_MODE;
      day_low_percent    <= RESET_DAY_LOW_PERCENT;
      day_high_percent   <= RESET_DAY_HIGH_PERCENT;
      night_low_percent  <= RESET_NIGHT_LOW_PERCENT;
      night_high_percent <= RESET_NIGHT_HIGH_PERCENT;
      alert_after_ticks  <= RESET_ALERT_AFTER_TICKS;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CHARGE_MODE: begin
          if (mode_change) charge_mode <= mode_t'(mode_value);
        end
        REG_DAY_LOW_PERCENT:    day_low_percent    <= cfg_data[6:0];
        REG_DAY_HIGH_PERCENT:   day_high_percent   <= cfg_data[6:0];
        REG_NIGHT_LOW_PERCENT:  night_low_percent  <= cfg_data[6:0];
        REG_NIGHT_HIGH_PERCENT: night_high_percent <= cfg_data[6:0];
        REG_ALERT_AFTER_TICKS:  alert_after_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    use_window = 1'b0;
    win_low    = day_low_percent;
    win_high   = day_high_percent;
    case (charge_mode)
      MODE_DAY: begin
        use_window = 1'b1;
      end
      MODE_NIGHT: begin
        use_window = 1'b1;
        win_low    = night_low_percent;
        win_high   = night_high_percent;
      end
      default: use_window = 1'b0;
    endcase
  end

  generate
    if (COUNT_BITS > 8) begin : g_cap
      always_comb begin
        shown_count = (|mismatch_counter_next[COUNT_BITS-1:8]) ? 8'hFF
                                                              : mismatch_counter_next[7:0];
      end
    end else begin : g_nocap
      always_comb begin
        shown_count = 8'(mismatch_counter_next);
      end
    end
  endgenerate

  always_comb begin
    discharging_next      = discharging;
    mismatch_counter_next = mismatch_counter;
    alert_active_next     = alert_active;
    charging_state_next   = charging_state;
    on                    = 1'b0;
    port_off              = (item.os_status == STATUS_DISCHARGING) || item.port_unplugged;
    result_next           = '0;

    if (item.device_connected) begin
      if (use_window) begin
        if (discharging) begin
          on               = (item.battery_percent <= win_low);
          discharging_next = !on;
        end else begin
          on               = !(item.battery_percent >= win_high);
          discharging_next = !on;
        end
      end else begin
        on = 1'b1;
      end

      if (item.os_status == STATUS_NOT_REPORTED) begin
        charging_state_next = on;
      end else begin
        charging_state_next = item.os_status inside {STATUS_CHARGING, STATUS_FULL};
        if (on && port_off) begin
          if (mismatch_counter != CNT_MAX) begin
            mismatch_counter_next = mismatch_counter + 1'b1;
          end
          result_next.retry_on = 1'b1;
          if ((CMP_W'(mismatch_counter_next) >= CMP_W'(alert_after_ticks)) && !alert_active) begin
            alert_active_next        = 1'b1;
            result_next.alert_raised = 1'b1;
          end
        end else begin
          if (alert_active) begin
            alert_active_next         = 1'b0;
            result_next.alert_cleared = 1'b1;
          end
          mismatch_counter_next = '0;
        end
      end
    end

    result_next.command_sent     = item.device_connected;
    result_next.charger_on       = on;
    result_next.charging_now     = charging_state_next;
    result_next.discharging_flag = discharging_next;
    result_next.mismatch_ticks   = shown_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      discharging      <= 1'b0;
      mismatch_counter <= '0;
      alert_active     <= 1'b0;
      charging_state   <= 1'b0;
    end else if (mode_change) begin
      mismatch_counter <= '0;
      alert_active     <= 1'b0;
    end else if (accept) begin
      discharging      <= discharging_next;
      mismatch_counter <= mismatch_counter_next;
      alert_active     <= alert_active_next;
      charging_state   <= charging_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || take) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || take) begin
      if (skid_valid) begin
        result <= skid;
      end else if (accept) begin
        result <= result_next;
      end
    end else if (accept) begin
      skid <= result_next;
    end
  end

  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry held without a result word");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(result_valid && result_stall))
    else $error("skid entry filled while result was free");

  a_no_raise_and_clear: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.alert_raised && result.alert_cleared))
    else $error("alert raised and cleared in the same word");

  a_retry_needs_on: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.retry_on |-> result.charger_on && result.command_sent)
    else $error("retry issued without a charger-on command");

  a_link_down_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.command_sent |->
      !result.charger_on && !result.alert_raised && !result.alert_cleared)
    else $error("command or alert pulse with link down");

endmodule
